// ----- rtl/mirror_boundary_fir_filter_macros.svh -----
// Assertion macros shared by the filter's checker.
`ifndef MIRROR_BOUNDARY_FIR_FILTER_MACROS_SVH
`define MIRROR_BOUNDARY_FIR_FILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MBF_CHECK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MBF_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mbf_pkg.sv -----
// Shared constants and types for the mirror-boundary FIR filter.
package mbf_pkg;

    localparam int MAX_HALF_DEF      = 3;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int TAP_FRAC_BITS_DEF = 14;

    localparam int TAP_BITS      = 16;
    localparam int NTAPS         = 7;
    localparam int HW_BITS       = 2;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic signed [TAP_BITS-1:0] TAP_ONE = 16'sh4000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_HALF_WIDTH,
        CFG_TAP_0,
        CFG_TAP_1,
        CFG_TAP_2,
        CFG_TAP_3,
        CFG_TAP_4,
        CFG_TAP_5,
        CFG_TAP_6
    } cfg_index_t;

endpackage

// ----- rtl/mirror_boundary_fir_filter.sv -----
// Top level of the mirror-boundary FIR filter.
// Odd-length FIR over a line of samples with the edge sample repeated at both line ends.
// One sample is taken per cycle while sample_stall is low. Results leave one per cycle,
// unless result_stall holds them, through a four-register path (job, products, sum,
// rounded output). The sample that completes 2H+1 samples of a line releases H+1 results,
// a line-end sample up to 2H+1; the job register issues them one per cycle unless stalled
// and stalls the input until the last is issued. All tap lanes multiply in parallel.
module mirror_boundary_fir_filter #(
    parameter int MAX_HALF      = mbf_pkg::MAX_HALF_DEF,
    parameter int SAMPLE_BITS   = mbf_pkg::SAMPLE_BITS_DEF,
    parameter int TAP_FRAC_BITS = mbf_pkg::TAP_FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    write_en,
    input  logic [mbf_pkg::CFG_IDX_BITS-1:0]        reg_index,
    input  logic [mbf_pkg::CFG_DATA_BITS-1:0]       write_data,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]           sample,
    input  logic                                    line_end,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [SAMPLE_BITS-1:0]           value,
    output logic                                    final_res,
    output logic                                    too_short
);

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int NLANE = (WIN < mbf_pkg::NTAPS) ? WIN : mbf_pkg::NTAPS;
    localparam int RW    = $clog2(WIN);
    localparam int CW    = $clog2(WIN + 1);
    localparam int XW    = RW + 2;
    localparam int SW    = RW + 3;
    localparam int PW    = SAMPLE_BITS + mbf_pkg::TAP_BITS;
    localparam int ACC_W = PW + $clog2(NLANE) + 1;

    localparam logic signed [SW-1:0]    ONE_S  = SW'(1);
    localparam logic signed [SW-1:0]    WIN_S  = SW'(WIN);
    localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(64'sd1 <<< (TAP_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef struct packed {
        logic          ok;
        logic [RW-1:0] idx;
    } tap_src_t;

    // window position feeding tap j for output offset r
    function automatic tap_src_t tap_src(input logic first, input logic at_end,
                                         input logic [RW-1:0] h, input logic [RW-1:0] r,
                                         input logic [RW-1:0] j);
        logic signed [SW-1:0] hs;
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] js;
        logic signed [SW-1:0] i;
        logic signed [SW-1:0] ix;
        tap_src_t             s;
        hs = $signed({3'b000, h});
        rs = $signed({3'b000, r});
        js = $signed({3'b000, j});
        if (first)
        begin
            i = hs + hs + hs - rs - js;
            if (i < 0)
            begin
                i = -i - ONE_S;
            end
            if (at_end && (i > hs + hs))
            begin
                i = (hs <<< 2) + ONE_S - i;
            end
            ix = hs + hs - i;
        end
        else
        begin
            ix = js + rs - hs;
            if (at_end && (ix < 0))
            begin
                ix = -ix - ONE_S;
            end
        end
        s.ok  = (ix >= 0) && (ix < WIN_S);
        s.idx = ix[RW-1:0];
        return s;
    endfunction

    // configuration
    logic [mbf_pkg::HW_BITS-1:0]         hw_reg;
    logic signed [mbf_pkg::TAP_BITS-1:0] tap_reg [mbf_pkg::NTAPS];

    // line state
    logic signed [SAMPLE_BITS-1:0] win_reg [WIN];
    logic [CW-1:0]                 seen_reg;

    // job stage
    logic                          job_v_reg;
    logic signed [SAMPLE_BITS-1:0] job_win_reg [WIN];
    logic [RW-1:0]                 job_h_reg;
    logic                          job_first_reg;
    logic                          job_end_reg;
    logic                          job_err_reg;
    logic [RW-1:0]                 job_r_reg;
    logic [RW-1:0]                 job_stop_reg;

    // product stage
    logic                          prod_v_reg;
    logic                          prod_fin_reg;
    logic                          prod_err_reg;
    logic signed [PW-1:0]          prod_reg [NLANE];

    // sum stage
    logic                          sum_v_reg;
    logic                          sum_fin_reg;
    logic                          sum_err_reg;
    logic signed [ACC_W-1:0]       sum_reg;

    // output stage
    logic                          out_v_reg;
    logic                          final_reg;
    logic                          short_reg;
    logic signed [SAMPLE_BITS-1:0] value_reg;

    logic                          o_rdy;
    logic                          s_rdy;
    logic                          p_rdy;
    logic                          issue;
    logic                          job_last;
    logic                          s_acc;
    logic [RW-1:0]                 h_cur;
    logic [RW:0]                   two_h_w;
    logic [RW-1:0]                 two_h;
    logic [XW-1:0]                 prev_x;
    logic [XW-1:0]                 need_m1;
    logic                          first;
    logic                          short_line;
    logic                          beyond;
    logic                          has_job;
    logic [RW-1:0]                 start_r;
    logic [RW-1:0]                 stop_r;
    logic [CW-1:0]                 seen_next;
    logic signed [SAMPLE_BITS-1:0] sel [NLANE];
    logic signed [ACC_W-1:0]       sum_next;
    logic signed [ACC_W-1:0]       rnd;
    logic signed [SAMPLE_BITS-1:0] value_next;

    // handshake chain
    assign o_rdy        = !out_v_reg || !result_stall;
    assign s_rdy        = !sum_v_reg || o_rdy;
    assign p_rdy        = !prod_v_reg || s_rdy;
    assign issue        = job_v_reg && p_rdy;
    assign job_last     = (job_r_reg == job_stop_reg);
    assign sample_stall = job_v_reg && !(issue && job_last);
    assign s_acc        = sample_valid && !sample_stall;

    // line bookkeeping
    always_comb
    begin
        h_cur      = (RW'(hw_reg) > RW'(MAX_HALF)) ? RW'(MAX_HALF) : RW'(hw_reg);
        two_h_w    = {h_cur, 1'b0};
        two_h      = two_h_w[RW-1:0];
        prev_x     = XW'(seen_reg);
        need_m1    = XW'(two_h);
        first      = (prev_x == need_m1);
        short_line = (prev_x < need_m1);
        beyond     = (prev_x > need_m1);
        has_job    = line_end || first || beyond;
        if (line_end && short_line)
        begin
            start_r = '0;
        end
        else if (first)
        begin
            start_r = two_h;
        end
        else
        begin
            start_r = h_cur;
        end
        stop_r = line_end ? '0 : h_cur;
        if (line_end)
        begin
            seen_next = '0;
        end
        else if (seen_reg < CW'(WIN))
        begin
            seen_next = seen_reg + CW'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    // tap lanes
    always_comb
    begin
        tap_src_t src;
        for (int k = 0; k < NLANE; k++)
        begin
            src = tap_src(job_first_reg, job_end_reg, job_h_reg, job_r_reg, RW'(k));
            if (src.ok && !job_err_reg && ({1'b0, RW'(k)} <= {job_h_reg, 1'b0}))
            begin
                sel[k] = job_win_reg[src.idx];
            end
            else
            begin
                sel[k] = '0;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NLANE; k++)
        begin
            sum_next = sum_next + ACC_W'(prod_reg[k]);
        end
    end

    // round half up, then clamp
    always_comb
    begin
        rnd = (sum_reg + HALF) >>> TAP_FRAC_BITS;
        if (rnd > SAT_HI)
        begin
            value_next = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rnd < SAT_LO)
        begin
            value_next = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            value_next = rnd[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= '0;
            for (int k = 0; k < mbf_pkg::NTAPS; k++)
            begin
                tap_reg[k] <= (k == 0) ? mbf_pkg::TAP_ONE : '0;
            end
        end
        else if (write_en)
        begin
            unique case (reg_index) inside
                mbf_pkg::CFG_HALF_WIDTH:
                begin
                    hw_reg <= write_data[mbf_pkg::HW_BITS-1:0];
                end
                [mbf_pkg::CFG_TAP_0:mbf_pkg::CFG_TAP_6]:
                begin
                    tap_reg[reg_index - mbf_pkg::CFG_IDX_BITS'(1)] <= $signed(write_data);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            job_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            sum_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
            for (int k = 0; k < WIN; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            if (s_acc)
            begin
                seen_reg   <= seen_next;
                win_reg[0] <= sample;
                for (int k = 1; k < WIN; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
            end
            if (s_acc && has_job)
            begin
                job_v_reg <= 1'b1;
            end
            else if (issue && job_last)
            begin
                job_v_reg <= 1'b0;
            end
            if (p_rdy)
            begin
                prod_v_reg <= issue;
            end
            if (s_rdy)
            begin
                sum_v_reg <= prod_v_reg;
            end
            if (o_rdy)
            begin
                out_v_reg <= sum_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc && has_job)
        begin
            job_win_reg[0] <= sample;
            for (int k = 1; k < WIN; k++)
            begin
                job_win_reg[k] <= win_reg[k-1];
            end
            job_h_reg     <= h_cur;
            job_first_reg <= first;
            job_end_reg   <= line_end;
            job_err_reg   <= line_end && short_line;
            job_r_reg     <= start_r;
            job_stop_reg  <= stop_r;
        end
        else if (issue)
        begin
            job_r_reg <= job_r_reg - RW'(1);
        end
        if (p_rdy)
        begin
            prod_fin_reg <= job_end_reg && job_last;
            prod_err_reg <= job_err_reg;
            for (int k = 0; k < NLANE; k++)
            begin
                prod_reg[k] <= sel[k] * tap_reg[k];
            end
        end
        if (s_rdy)
        begin
            sum_fin_reg <= prod_fin_reg;
            sum_err_reg <= prod_err_reg;
            sum_reg     <= sum_next;
        end
        if (o_rdy)
        begin
            final_reg <= sum_fin_reg;
            short_reg <= sum_err_reg;
            value_reg <= value_next;
        end
    end

    assign result_valid = out_v_reg;
    assign value        = value_reg;
    assign final_res    = final_reg;
    assign too_short    = short_reg;

endmodule

// ----- rtl/mbf_checker.sv -----
// Port-level checker for the mirror-boundary FIR filter, bound to the top level.
`include "mirror_boundary_fir_filter_macros.svh"

module mbf_checker #(
    parameter int SAMPLE_BITS = mbf_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic signed [SAMPLE_BITS-1:0] value,
    input logic                          final_res,
    input logic                          too_short
);

    `MBF_CHECK_NOW(a_short_is_final, result_valid && too_short, final_res, "short line beat not final")
    `MBF_CHECK_NOW(a_short_is_zero, result_valid && too_short, value == '0, "short line beat not zero")
    `MBF_CHECK_NEXT(a_valid_held, result_valid && result_stall, result_valid, "result dropped on stall")
    `MBF_CHECK_NEXT(a_beat_held, result_valid && result_stall, $stable(value) && $stable(final_res) && $stable(too_short), "stalled beat changed")

endmodule

bind mirror_boundary_fir_filter mbf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_mbf_checker (.*);
